### rtl/tisd_pkg.sv
// shared types, key codes and byte helpers for the terminal input decoder
`default_nettype none
package tisd_pkg;

    typedef enum logic [2:0] {
        MODE_GROUND = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_CSI    = 3'd2,
        MODE_SS3    = 3'd3,
        MODE_UTF8   = 3'd4
    } t_mode;

    localparam logic [4:0] KEY_CHAR  = 5'd0;
    localparam logic [4:0] KEY_ESC   = 5'd1;
    localparam logic [4:0] KEY_ENTER = 5'd2;
    localparam logic [4:0] KEY_TAB   = 5'd3;
    localparam logic [4:0] KEY_BKSP  = 5'd4;
    localparam logic [4:0] KEY_UP    = 5'd5;
    localparam logic [4:0] KEY_DOWN  = 5'd6;
    localparam logic [4:0] KEY_LEFT  = 5'd7;
    localparam logic [4:0] KEY_RIGHT = 5'd8;
    localparam logic [4:0] KEY_HOME  = 5'd9;
    localparam logic [4:0] KEY_END   = 5'd10;
    localparam logic [4:0] KEY_INS   = 5'd11;
    localparam logic [4:0] KEY_DEL   = 5'd12;
    localparam logic [4:0] KEY_PGUP  = 5'd13;
    localparam logic [4:0] KEY_PGDN  = 5'd14;
    localparam logic [4:0] KEY_F1    = 5'd15;
    localparam logic [4:0] KEY_F2    = 5'd16;
    localparam logic [4:0] KEY_F3    = 5'd17;
    localparam logic [4:0] KEY_F4    = 5'd18;
    localparam logic [4:0] KEY_F5    = 5'd19;
    localparam logic [4:0] KEY_F6    = 5'd20;
    localparam logic [4:0] KEY_F7    = 5'd21;
    localparam logic [4:0] KEY_F8    = 5'd22;
    localparam logic [4:0] KEY_F9    = 5'd23;
    localparam logic [4:0] KEY_F10   = 5'd24;
    localparam logic [4:0] KEY_F11   = 5'd25;
    localparam logic [4:0] KEY_F12   = 5'd26;

    localparam logic [2:0] MOD_SHIFT = 3'b001;
    localparam logic [2:0] MOD_ALT   = 3'b010;
    localparam logic [2:0] MOD_CTRL  = 3'b100;

    localparam logic [1:0] ACT_PRESS   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_MOVE    = 2'd2;

    localparam logic [2:0] BTN_WHEEL_UP   = 3'd4;
    localparam logic [2:0] BTN_WHEEL_DOWN = 3'd5;

    localparam logic [7:0] BYTE_ESC  = 8'h1b;
    localparam logic [7:0] BYTE_LB   = 8'h5b;
    localparam logic [7:0] BYTE_O    = 8'h4f;
    localparam logic [7:0] BYTE_SEMI = 8'h3b;
    localparam logic [7:0] BYTE_LT   = 8'h3c;
    localparam logic [7:0] BYTE_M    = 8'h4d;
    localparam logic [7:0] BYTE_LM   = 8'h6d;
    localparam logic [7:0] BYTE_ZERO = 8'h30;

    typedef struct packed {
        logic        has_event;
        logic        event_kind;
        logic [4:0]  key_code;
        logic [2:0]  modifiers;
        logic [31:0] text_bytes;
        logic [2:0]  text_len;
        logic [2:0]  mouse_button;
        logic [1:0]  mouse_action;
        logic [15:0] mouse_row;
        logic [15:0] mouse_col;
        logic        seq_pending;
    } t_res;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if (b[7:5] == 3'b110) len = 3'd2;
        else if (b[7:4] == 4'b1110) len = 3'd3;
        else if (b[7:3] == 5'b11110) len = 3'd4;
        else len = 3'd1;
        return len;
    endfunction

    function automatic t_res key_evt(input logic [4:0] key, input logic [2:0] mods,
                                     input logic [31:0] text, input logic [2:0] tlen);
        t_res r;
        r = '0;
        r.has_event  = 1'b1;
        r.key_code   = key;
        r.modifiers  = mods;
        r.text_bytes = text;
        r.text_len   = tlen;
        return r;
    endfunction

    // event for a byte seen in ground state, no event for esc and for any byte with bit 7 set
    function automatic t_res ground_evt(input logic [7:0] b, input logic alt);
        t_res       r;
        logic [2:0] am;
        am = alt ? MOD_ALT : 3'b000;
        r  = '0;
        if (b == BYTE_ESC || b[7]) begin
            r = '0;
        end else if (b == 8'h0d || b == 8'h0a) begin
            r = key_evt(KEY_ENTER, am, 32'h0, 3'd0);
        end else if (b == 8'h09) begin
            r = key_evt(KEY_TAB, am, 32'h0, 3'd0);
        end else if (b == 8'h7f || b == 8'h08) begin
            r = key_evt(KEY_BKSP, am, 32'h0, 3'd0);
        end else if (b == 8'h00) begin
            r = key_evt(KEY_CHAR, am | MOD_CTRL, 32'h20, 3'd1);
        end else if (b <= 8'h1a) begin
            r = key_evt(KEY_CHAR, am | MOD_CTRL, {24'h0, b + 8'h60}, 3'd1);
        end else if (b >= 8'h1c && b <= 8'h1f) begin
            r = key_evt(KEY_CHAR, am | MOD_CTRL, {24'h0, b + 8'h40}, 3'd1);
        end else begin
            r = key_evt(KEY_CHAR, am, {24'h0, b}, 3'd1);
        end
        return r;
    endfunction

    function automatic logic [4:0] letter_key(input logic [7:0] b);
        logic [4:0] k;
        case (b)
            8'h41:   k = KEY_UP;
            8'h42:   k = KEY_DOWN;
            8'h43:   k = KEY_RIGHT;
            8'h44:   k = KEY_LEFT;
            8'h48:   k = KEY_HOME;
            8'h46:   k = KEY_END;
            8'h50:   k = KEY_F1;
            8'h51:   k = KEY_F2;
            8'h52:   k = KEY_F3;
            8'h53:   k = KEY_F4;
            default: k = KEY_CHAR;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] vt_number_key(input logic [7:0] n);
        logic [4:0] k;
        case (n)
            8'd1:    k = KEY_HOME;
            8'd2:    k = KEY_INS;
            8'd3:    k = KEY_DEL;
            8'd4:    k = KEY_END;
            8'd5:    k = KEY_PGUP;
            8'd6:    k = KEY_PGDN;
            8'd11:   k = KEY_F1;
            8'd12:   k = KEY_F2;
            8'd13:   k = KEY_F3;
            8'd14:   k = KEY_F4;
            8'd15:   k = KEY_F5;
            8'd17:   k = KEY_F6;
            8'd18:   k = KEY_F7;
            8'd19:   k = KEY_F8;
            8'd20:   k = KEY_F9;
            8'd21:   k = KEY_F10;
            8'd23:   k = KEY_F11;
            8'd24:   k = KEY_F12;
            default: k = KEY_CHAR;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

### rtl/terminal_input_sequence_decoder_unit.sv
// terminal input decoder: utf-8, esc, csi, ss3 and sgr mouse, one result beat per input beat
// the result of an accepted input beat is registered, in the result register or, while that is held, in the skid
// throughput: one beat per cycle while the skid is empty, set by the single state update between input and result
// a two-entry output buffer (result register plus skid) takes one more beat after a stall
// reset: synchronous active low, returns to ground state and empties the output buffer
`default_nettype none
module terminal_input_sequence_decoder_unit
    import tisd_pkg::*;
#(
    parameter int PARAM_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_req_type,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_has_event,
    output logic             o_event_kind,
    output logic [4:0]       o_key_code,
    output logic [2:0]       o_modifiers,
    output logic [31:0]      o_text_bytes,
    output logic [2:0]       o_text_len,
    output logic [2:0]       o_mouse_button,
    output logic [1:0]       o_mouse_action,
    output logic [15:0]      o_mouse_row,
    output logic [15:0]      o_mouse_col,
    output logic             o_seq_pending
);

    localparam int PB  = PARAM_BITS;
    localparam int SW  = (PB > 16) ? PB : 16;
    localparam int MW  = PB + 4;

    t_mode                r_mode, n_mode;
    logic                 r_alt, n_alt;
    logic [31:0]          r_buf, n_buf;
    logic [2:0]           r_need, n_need;
    logic [2:0]           r_have, n_have;
    logic                 r_first, n_first;
    logic                 r_lt, n_lt;
    logic [2:0][PB-1:0]   r_par, n_par;
    logic [1:0]           r_cnt, n_cnt;

    t_res                 r_out, r_skid, w_res;
    logic                 r_out_vld, r_skid_vld;

    logic                 w_acc, w_take, w_final, w_cont, w_digit;
    logic [7:0]           b;
    logic [MW-1:0]        w_acc_val;
    logic [PB-1:0]        w_cur, w_sat;
    logic [SW-1:0]        w_row, w_col;

    assign b       = i_data_byte;
    assign w_acc   = i_in_valid && !r_skid_vld;
    assign w_take  = r_out_vld && !i_out_stall;
    assign w_final = b >= 8'h40 && b <= 8'h7e;
    assign w_cont  = b[7:6] == 2'b10 && r_have < 3'd4;
    assign w_digit = b >= BYTE_ZERO && b <= 8'h39;

    // digit accumulate on the current parameter, saturating
    assign w_cur     = r_par[r_cnt[1] ? 2'd2 : r_cnt];
    assign w_acc_val = ({4'b0, w_cur} << 3) + ({4'b0, w_cur} << 1) + MW'(b[3:0]);
    assign w_sat     = (w_acc_val > {4'b0, {PB{1'b1}}}) ? {PB{1'b1}} : w_acc_val[PB-1:0];

    assign w_row = (r_par[2] == '0) ? '0 : SW'(r_par[2] - PB'(1));
    assign w_col = (r_par[1] == '0) ? '0 : SW'(r_par[1] - PB'(1));

    // next state
    always_comb begin
        n_mode  = r_mode;
        n_alt   = r_alt;
        n_buf   = r_buf;
        n_need  = r_need;
        n_have  = r_have;
        n_first = r_first;
        n_lt    = r_lt;
        n_par   = r_par;
        n_cnt   = r_cnt;
        if (i_req_type) begin
            n_mode  = MODE_GROUND;
            n_alt   = 1'b0;
            n_buf   = '0;
            n_need  = '0;
            n_have  = '0;
            n_first = 1'b0;
            n_lt    = 1'b0;
            n_par   = '0;
            n_cnt   = '0;
        end else begin
            case (r_mode)
                MODE_GROUND, MODE_ESC, MODE_UTF8: begin
                    if (r_mode == MODE_UTF8 && w_cont) begin
                        case (r_have[1:0])
                            2'd1:    n_buf = r_buf | {16'h0, b, 8'h0};
                            2'd2:    n_buf = r_buf | {8'h0, b, 16'h0};
                            2'd3:    n_buf = r_buf | {b, 24'h0};
                            default: n_buf = r_buf | {24'h0, b};
                        endcase
                        n_have = r_have + 3'd1;
                        if (r_have + 3'd1 >= r_need) begin
                            n_mode = MODE_GROUND;
                            n_buf  = '0;
                            n_need = '0;
                            n_have = '0;
                            n_alt  = 1'b0;
                        end
                    end else if (r_mode == MODE_ESC && b == BYTE_LB) begin
                        n_mode  = MODE_CSI;
                        n_first = 1'b0;
                        n_lt    = 1'b0;
                        n_par   = '0;
                        n_cnt   = '0;
                    end else if (r_mode == MODE_ESC && b == BYTE_O) begin
                        n_mode = MODE_SS3;
                    end else begin
                        n_mode = MODE_GROUND;
                        n_buf  = '0;
                        n_need = '0;
                        n_have = '0;
                        n_alt  = 1'b0;
                        if (b == BYTE_ESC) begin
                            n_mode = MODE_ESC;
                        end else if (b[7] && lead_length(b) != 3'd1) begin
                            n_mode = MODE_UTF8;
                            n_buf  = {24'h0, b};
                            n_need = lead_length(b);
                            n_have = 3'd1;
                            n_alt  = (r_mode == MODE_ESC);
                        end
                    end
                end
                MODE_CSI: begin
                    if (w_final) begin
                        n_mode  = MODE_GROUND;
                        n_first = 1'b0;
                        n_lt    = 1'b0;
                        n_par   = '0;
                        n_cnt   = '0;
                    end else begin
                        if (!r_first) begin
                            n_first = 1'b1;
                            n_lt    = (b == BYTE_LT);
                        end
                        if (b == BYTE_SEMI) begin
                            if (r_cnt != 2'd3) n_cnt = r_cnt + 2'd1;
                        end else if (w_digit && r_cnt != 2'd3) begin
                            n_par[r_cnt] = w_sat;
                        end
                    end
                end
                MODE_SS3: begin
                    n_mode = MODE_GROUND;
                end
                default: begin
                    n_mode  = MODE_GROUND;
                    n_alt   = 1'b0;
                    n_buf   = '0;
                    n_need  = '0;
                    n_have  = '0;
                    n_first = 1'b0;
                    n_lt    = 1'b0;
                    n_par   = '0;
                    n_cnt   = '0;
                end
            endcase
        end
    end

    // result of this beat
    always_comb begin
        logic [4:0] k;
        logic [2:0] m;
        logic [PB-1:0] p1m;
        w_res = '0;
        k     = KEY_CHAR;
        m     = 3'b000;
        p1m   = r_par[1] - PB'(1);
        if (i_req_type) begin
            if (r_mode == MODE_ESC) w_res = key_evt(KEY_ESC, 3'b000, 32'h0, 3'd0);
        end else begin
            case (r_mode)
                MODE_GROUND: begin
                    w_res = ground_evt(b, 1'b0);
                end
                MODE_ESC: begin
                    if (b == BYTE_ESC) w_res = key_evt(KEY_ESC, 3'b000, 32'h0, 3'd0);
                    else if (b != BYTE_LB && b != BYTE_O) w_res = ground_evt(b, 1'b1);
                end
                MODE_UTF8: begin
                    if (w_cont) begin
                        if (r_have + 3'd1 >= r_need) begin
                            w_res = key_evt(KEY_CHAR, r_alt ? MOD_ALT : 3'b000,
                                            n_buf, r_have + 3'd1);
                            case (r_have[1:0])
                                2'd1:    w_res.text_bytes = r_buf | {16'h0, b, 8'h0};
                                2'd2:    w_res.text_bytes = r_buf | {8'h0, b, 16'h0};
                                2'd3:    w_res.text_bytes = r_buf | {b, 24'h0};
                                default: w_res.text_bytes = r_buf | {24'h0, b};
                            endcase
                        end
                    end else begin
                        w_res = ground_evt(b, 1'b0);
                    end
                end
                MODE_SS3: begin
                    k = letter_key(b);
                    if (k != KEY_CHAR) w_res = key_evt(k, 3'b000, 32'h0, 3'd0);
                end
                MODE_CSI: begin
                    if (w_final && r_lt && (b == BYTE_M || b == BYTE_LM)) begin
                        if (r_cnt >= 2'd2) begin
                            w_res.has_event  = 1'b1;
                            w_res.event_kind = 1'b1;
                            w_res.modifiers  = r_par[0][4:2];
                            w_res.mouse_row  = (w_row > SW'(16'hffff)) ? 16'hffff : w_row[15:0];
                            w_res.mouse_col  = (w_col > SW'(16'hffff)) ? 16'hffff : w_col[15:0];
                            if (r_par[0][6]) begin
                                w_res.mouse_button = (r_par[0][1:0] == 2'd0) ?
                                                     BTN_WHEEL_UP : BTN_WHEEL_DOWN;
                                w_res.mouse_action = ACT_PRESS;
                            end else begin
                                w_res.mouse_button = {1'b0, r_par[0][1:0]};
                                if (r_par[0][5]) w_res.mouse_action = ACT_MOVE;
                                else if (b == BYTE_M) w_res.mouse_action = ACT_PRESS;
                                else w_res.mouse_action = ACT_RELEASE;
                            end
                        end
                    end else if (w_final) begin
                        if (r_cnt != 2'd0 && r_par[1] != '0) m = p1m[2:0];
                        if (b == 8'h7e) begin
                            k = (r_par[0] > PB'(8'hff)) ? KEY_CHAR
                                                        : vt_number_key(r_par[0][7:0]);
                        end else if (b == 8'h5a) begin
                            k = KEY_TAB;
                            m = m | MOD_SHIFT;
                        end else begin
                            k = letter_key(b);
                        end
                        if (k != KEY_CHAR) w_res = key_evt(k, m, 32'h0, 3'd0);
                    end
                end
                default: w_res = '0;
            endcase
        end
        w_res.seq_pending = (n_mode != MODE_GROUND);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_GROUND;
            r_alt   <= 1'b0;
            r_buf   <= '0;
            r_need  <= '0;
            r_have  <= '0;
            r_first <= 1'b0;
            r_lt    <= 1'b0;
            r_par   <= '0;
            r_cnt   <= '0;
        end else if (w_acc) begin
            r_mode  <= n_mode;
            r_alt   <= n_alt;
            r_buf   <= n_buf;
            r_need  <= n_need;
            r_have  <= n_have;
            r_first <= n_first;
            r_lt    <= n_lt;
            r_par   <= n_par;
            r_cnt   <= n_cnt;
        end
    end

    // result register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_take) begin
            if (r_skid_vld) begin
                r_out      <= r_skid;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= w_acc;
                if (w_acc) r_out <= w_res;
            end
        end else if (w_acc) begin
            if (!r_out_vld) begin
                r_out     <= w_res;
                r_out_vld <= 1'b1;
            end else begin
                r_skid     <= w_res;
                r_skid_vld <= 1'b1;
            end
        end
    end

    assign o_in_stall     = r_skid_vld;
    assign o_out_valid    = r_out_vld;
    assign o_has_event    = r_out.has_event;
    assign o_event_kind   = r_out.event_kind;
    assign o_key_code     = r_out.key_code;
    assign o_modifiers    = r_out.modifiers;
    assign o_text_bytes   = r_out.text_bytes;
    assign o_text_len     = r_out.text_len;
    assign o_mouse_button = r_out.mouse_button;
    assign o_mouse_action = r_out.mouse_action;
    assign o_mouse_row    = r_out.mouse_row;
    assign o_mouse_col    = r_out.mouse_col;
    assign o_seq_pending  = r_out.seq_pending;

endmodule
`default_nettype wire

### rtl/tisd_checker.sv
// port-level checks for the terminal input decoder and their bind
`default_nettype none
module tisd_checker
    import tisd_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_has_event,
    input wire logic        o_event_kind,
    input wire logic [4:0]  o_key_code,
    input wire logic [31:0] o_text_bytes,
    input wire logic [2:0]  o_text_len,
    input wire logic [15:0] o_mouse_row
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_text_bytes))
        else $error("stalled result beat changed");

    a_no_event_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_event |->
            o_key_code == KEY_CHAR && o_text_len == 3'd0 && o_mouse_row == 16'h0)
        else $error("fields set on a beat without event");

    a_mouse_no_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_kind |-> o_has_event && o_text_len == 3'd0)
        else $error("mouse beat carries text");

    a_text_is_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_text_len != 3'd0 |->
            o_key_code == KEY_CHAR && !o_event_kind && o_text_len <= 3'd4)
        else $error("text on a non character beat");

endmodule

bind terminal_input_sequence_decoder_unit tisd_checker u_tisd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_has_event  (o_has_event),
    .o_event_kind (o_event_kind),
    .o_key_code   (o_key_code),
    .o_text_bytes (o_text_bytes),
    .o_text_len   (o_text_len),
    .o_mouse_row  (o_mouse_row)
);
`default_nettype wire

### tb/sv/tb_terminal_input_sequence_decoder_unit.sv
// testbench for the terminal input sequence decoder: directed and random byte streams
`default_nettype none
module tb_terminal_input_sequence_decoder_unit;
    import tisd_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_req_type;
    logic [7:0]  i_data_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_has_event;
    logic        o_event_kind;
    logic [4:0]  o_key_code;
    logic [2:0]  o_modifiers;
    logic [31:0] o_text_bytes;
    logic [2:0]  o_text_len;
    logic [2:0]  o_mouse_button;
    logic [1:0]  o_mouse_action;
    logic [15:0] o_mouse_row;
    logic [15:0] o_mouse_col;
    logic        o_seq_pending;

    terminal_input_sequence_decoder_unit dut (.*);

    localparam logic REQ_FEED  = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // predictor state
    t_mode       pm_mode;
    logic        pm_alt;
    logic [31:0] pm_ubuf;
    logic [2:0]  pm_uneed;
    logic [2:0]  pm_uhave;
    logic        pm_first;
    logic        pm_lt;
    logic [15:0] pm_par [3];
    logic [1:0]  pm_pcnt;

    t_res        expected_events[$];
    int          errors;
    int          beats_sent;
    int          events_seen;
    int          mice_seen;
    logic        rx_hold;
    logic        idle_free;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic logic [2:0] len_of_lead(input logic [7:0] b);
        if (b[7:5] == 3'b110) return 3'd2;
        if (b[7:4] == 4'b1110) return 3'd3;
        if (b[7:3] == 5'b11110) return 3'd4;
        return 3'd1;
    endfunction

    function automatic t_res mk_key(input logic [4:0] k, input logic [2:0] m,
                                    input logic [31:0] t, input logic [2:0] l);
        t_res r;
        r = '0;
        r.has_event = 1'b1;
        r.key_code = k;
        r.modifiers = m;
        r.text_bytes = t;
        r.text_len = l;
        return r;
    endfunction

    function automatic void clear_params();
        pm_first = 0; pm_lt = 0; pm_pcnt = 0;
        pm_par[0] = 0; pm_par[1] = 0; pm_par[2] = 0;
    endfunction

    function automatic void clear_all();
        pm_mode = MODE_GROUND; pm_alt = 0; pm_ubuf = 0; pm_uneed = 0; pm_uhave = 0;
        clear_params();
    endfunction

    function automatic void decode_ground(input logic [7:0] b, input logic alt, inout t_res r);
        logic [2:0] am;
        am = alt ? MOD_ALT : 3'b000;
        if (b == BYTE_ESC) begin
            pm_mode = MODE_ESC;
        end else if (b[7]) begin
            if (len_of_lead(b) != 3'd1) begin
                pm_mode = MODE_UTF8; pm_ubuf = {24'h0, b};
                pm_uneed = len_of_lead(b); pm_uhave = 3'd1; pm_alt = alt;
            end
        end else if (b == 8'h0d || b == 8'h0a) r = mk_key(KEY_ENTER, am, 0, 0);
        else if (b == 8'h09) r = mk_key(KEY_TAB, am, 0, 0);
        else if (b == 8'h7f || b == 8'h08) r = mk_key(KEY_BKSP, am, 0, 0);
        else if (b == 8'h00) r = mk_key(KEY_CHAR, am | MOD_CTRL, 32'h20, 3'd1);
        else if (b <= 8'h1a) r = mk_key(KEY_CHAR, am | MOD_CTRL, {24'h0, b + 8'h60}, 3'd1);
        else if (b >= 8'h1c && b <= 8'h1f)
            r = mk_key(KEY_CHAR, am | MOD_CTRL, {24'h0, b + 8'h40}, 3'd1);
        else r = mk_key(KEY_CHAR, am, {24'h0, b}, 3'd1);
    endfunction

    function automatic logic [4:0] final_key(input logic [7:0] b);
        case (b)
            "A": return KEY_UP;
            "B": return KEY_DOWN;
            "C": return KEY_RIGHT;
            "D": return KEY_LEFT;
            "H": return KEY_HOME;
            "F": return KEY_END;
            "P": return KEY_F1;
            "Q": return KEY_F2;
            "R": return KEY_F3;
            "S": return KEY_F4;
            default: return KEY_CHAR;
        endcase
    endfunction

    function automatic logic [4:0] tilde_code(input logic [15:0] n);
        case (n)
            1: return KEY_HOME;   2: return KEY_INS;   3: return KEY_DEL;
            4: return KEY_END;    5: return KEY_PGUP;  6: return KEY_PGDN;
            11: return KEY_F1;    12: return KEY_F2;   13: return KEY_F3;
            14: return KEY_F4;    15: return KEY_F5;   17: return KEY_F6;
            18: return KEY_F7;    19: return KEY_F8;   20: return KEY_F9;
            21: return KEY_F10;   23: return KEY_F11;  24: return KEY_F12;
            default: return KEY_CHAR;
        endcase
    endfunction

    function automatic void decode_csi_final(input logic [7:0] b, inout t_res r);
        logic [2:0]  m;
        logic [4:0]  k;
        logic [15:0] code;
        if (pm_lt && (b == BYTE_M || b == BYTE_LM)) begin
            if (pm_pcnt >= 2) begin
                code = pm_par[0];
                r = '0;
                r.has_event = 1; r.event_kind = 1;
                r.modifiers = code[4:2];
                r.mouse_row = pm_par[2] > 0 ? 16'(pm_par[2] - 16'd1) : 16'd0;
                r.mouse_col = pm_par[1] > 0 ? 16'(pm_par[1] - 16'd1) : 16'd0;
                if (code[6]) begin
                    r.mouse_button = code[1:0] == 0 ? BTN_WHEEL_UP : BTN_WHEEL_DOWN;
                    r.mouse_action = ACT_PRESS;
                end else begin
                    r.mouse_button = {1'b0, code[1:0]};
                    if (code[5]) r.mouse_action = ACT_MOVE;
                    else r.mouse_action = b == BYTE_M ? ACT_PRESS : ACT_RELEASE;
                end
            end
            return;
        end
        m = 0;
        if (pm_pcnt >= 1 && pm_par[1] != 0) m = 3'(pm_par[1] - 1);
        if (b == "Z") r = mk_key(KEY_TAB, m | MOD_SHIFT, 0, 0);
        else if (b == "~") begin
            k = tilde_code(pm_par[0]);
            if (k != KEY_CHAR) r = mk_key(k, m, 0, 0);
        end else begin
            k = final_key(b);
            if (k != KEY_CHAR) r = mk_key(k, m, 0, 0);
        end
    endfunction

    function automatic t_res predict_beat(input logic req, input logic [7:0] b);
        t_res     r;
        logic [19:0] v;
        r = '0;
        if (req) begin
            if (pm_mode == MODE_ESC) r = mk_key(KEY_ESC, 0, 0, 0);
            clear_all();
        end else begin
            case (pm_mode)
                MODE_GROUND: decode_ground(b, 0, r);
                MODE_ESC: begin
                    if (b == BYTE_LB) begin pm_mode = MODE_CSI; clear_params(); end
                    else if (b == BYTE_O) pm_mode = MODE_SS3;
                    else if (b == BYTE_ESC) r = mk_key(KEY_ESC, 0, 0, 0);
                    else begin pm_mode = MODE_GROUND; decode_ground(b, 1, r); end
                end
                MODE_CSI: begin
                    if (b >= 8'h40 && b <= 8'h7e) begin
                        decode_csi_final(b, r);
                        pm_mode = MODE_GROUND; clear_params();
                    end else begin
                        if (!pm_first) begin pm_first = 1; pm_lt = b == BYTE_LT; end
                        if (b == BYTE_SEMI) begin
                            if (pm_pcnt < 3) pm_pcnt++;
                        end else if (b >= "0" && b <= "9" && pm_pcnt < 3) begin
                            v = 20'(pm_par[pm_pcnt] * 10 + (b - BYTE_ZERO));
                            pm_par[pm_pcnt] = v > 20'hffff ? 16'hffff : v[15:0];
                        end
                    end
                end
                MODE_SS3: begin
                    if (final_key(b) != KEY_CHAR) r = mk_key(final_key(b), 0, 0, 0);
                    pm_mode = MODE_GROUND;
                end
                MODE_UTF8: begin
                    if (b[7:6] == 2'b10 && pm_uhave < 4) begin
                        pm_ubuf |= {24'h0, b} << (8 * pm_uhave);
                        pm_uhave++;
                        if (pm_uhave >= pm_uneed) begin
                            r = mk_key(KEY_CHAR, pm_alt ? MOD_ALT : 0, pm_ubuf, pm_uhave);
                            clear_all();
                        end
                    end else begin
                        clear_all();
                        decode_ground(b, 0, r);
                    end
                end
                default: clear_all();
            endcase
        end
        r.seq_pending = pm_mode != MODE_GROUND;
        return r;
    endfunction

    function automatic bit idle_now();
        return !idle_free && $urandom_range(99) < 15;
    endfunction

    task automatic send_beat(input logic req, input logic [7:0] b);
        while (idle_now()) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1; i_req_type <= req; i_data_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_events.insert(expected_events.size(), predict_beat(req, b));
        beats_sent++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) send_beat(REQ_FEED, s[i]);
    endtask

    task automatic send_number(input int unsigned n);
        send_str($sformatf("%0d", n));
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (expected_events.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || rx_hold) i_out_stall <= rx_hold;
        else i_out_stall <= idle_now();
    end

    always @(posedge i_clk) begin
        t_res exp_r;
        t_res got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_has_event, o_event_kind, o_key_code, o_modifiers, o_text_bytes,
                    o_text_len, o_mouse_button, o_mouse_action, o_mouse_row, o_mouse_col,
                    o_seq_pending};
            if (expected_events.size() == 0) begin
                $display("%0t unexpected beat actual %h", $time, got);
                errors++;
            end else begin
                exp_r = expected_events.pop_front();
                if (got.has_event) events_seen++;
                if (got.event_kind) mice_seen++;
                if (got.has_event != exp_r.has_event)
                    $display("%0t has_event exp %h act %h", $time, exp_r.has_event, got.has_event);
                if (got.event_kind != exp_r.event_kind)
                    $display("%0t event_kind exp %h act %h", $time, exp_r.event_kind,
                             got.event_kind);
                if (got.key_code != exp_r.key_code)
                    $display("%0t key_code exp %h act %h", $time, exp_r.key_code, got.key_code);
                if (got.modifiers != exp_r.modifiers)
                    $display("%0t modifiers exp %h act %h", $time, exp_r.modifiers, got.modifiers);
                if (got.text_bytes != exp_r.text_bytes)
                    $display("%0t text_bytes exp %h act %h", $time, exp_r.text_bytes,
                             got.text_bytes);
                if (got.text_len != exp_r.text_len)
                    $display("%0t text_len exp %h act %h", $time, exp_r.text_len, got.text_len);
                if (got.mouse_button != exp_r.mouse_button)
                    $display("%0t mouse_button exp %h act %h", $time, exp_r.mouse_button,
                             got.mouse_button);
                if (got.mouse_action != exp_r.mouse_action)
                    $display("%0t mouse_action exp %h act %h", $time, exp_r.mouse_action,
                             got.mouse_action);
                if (got.mouse_row != exp_r.mouse_row)
                    $display("%0t mouse_row exp %h act %h", $time, exp_r.mouse_row, got.mouse_row);
                if (got.mouse_col != exp_r.mouse_col)
                    $display("%0t mouse_col exp %h act %h", $time, exp_r.mouse_col, got.mouse_col);
                if (got.seq_pending != exp_r.seq_pending)
                    $display("%0t seq_pending exp %h act %h", $time, exp_r.seq_pending,
                             got.seq_pending);
                if (got != exp_r) errors++;
            end
        end
    end

    task automatic test_directed();
        send_beat(REQ_FEED, 8'h00);
        send_beat(REQ_FEED, 8'hff);
        send_beat(REQ_FEED, "a");
        send_beat(REQ_FEED, 8'h0d);
        send_beat(REQ_FEED, 8'h1c);
        send_str("\033[1;5A");
        send_str("\033[24~");
        send_str("\033OP");
        send_str("\033\033");
        send_beat(REQ_FLUSH, 8'h00);
        send_beat(REQ_FEED, 8'h1b);
        send_beat(REQ_FEED, "x");
        send_beat(REQ_FEED, 8'hf0);
        send_str("\237\230\200");
        send_beat(REQ_FEED, 8'hc3);
        send_beat(REQ_FEED, "z");
        drain();
    endtask

    task automatic test_mouse_extremes();
        send_str("\033[<0;1;1M");
        send_str("\033[<99;99999;70000m");
        send_str("\033[<64;5M");
        send_str("\033[<96;0;0;7;8M");
        send_str("\033[Z");
        drain();
    endtask

    task automatic random_sequence();
        int          kind;
        int unsigned n;
        kind = $urandom_range(9);
        case (kind)
            0: send_beat(REQ_FEED, 8'($urandom));
            1: send_beat(REQ_FEED, 8'($urandom_range(8'h20, 8'h7e)));
            2: begin
                send_str("\033[");
                n = $urandom_range(4);
                for (int i = 0; i < n; i++) begin
                    send_number($urandom_range(1) ? $urandom_range(30) : $urandom);
                    if (i + 1 < n) send_beat(REQ_FEED, BYTE_SEMI);
                end
                send_beat(REQ_FEED, 8'($urandom_range(8'h40, 8'h7e)));
            end
            3: begin
                send_str("\033[<");
                send_number($urandom_range(127));
                send_beat(REQ_FEED, BYTE_SEMI);
                send_number($urandom_range(1) ? $urandom_range(300) : $urandom_range(99999));
                if ($urandom_range(5) != 0) begin
                    send_beat(REQ_FEED, BYTE_SEMI);
                    send_number($urandom_range(300));
                end
                send_beat(REQ_FEED, $urandom_range(1) ? BYTE_M : BYTE_LM);
            end
            4: begin
                send_str("\033O");
                send_beat(REQ_FEED, 8'($urandom_range(8'h40, 8'h55)));
            end
            5: begin
                n = $urandom_range(2, 4);
                send_beat(REQ_FEED, n == 2 ? 8'hc0 | 8'($urandom_range(31)) :
                                    n == 3 ? 8'he0 | 8'($urandom_range(15)) :
                                             8'hf0 | 8'($urandom_range(7)));
                for (int i = 1; i < n; i++)
                    send_beat(REQ_FEED, $urandom_range(7) == 0 ? 8'($urandom)
                                                               : 8'h80 | 8'($urandom_range(63)));
            end
            6: begin
                send_beat(REQ_FEED, BYTE_ESC);
                send_beat(REQ_FEED, 8'($urandom));
            end
            7: send_beat(REQ_FLUSH, 8'($urandom));
            8: send_beat(REQ_FEED, 8'($urandom_range(8'h1f)));
            default: begin
                send_beat(REQ_FEED, BYTE_ESC);
                if ($urandom_range(1)) send_beat(REQ_FLUSH, 8'($urandom));
            end
        endcase
    endtask

    task automatic test_random_stream();
        while (beats_sent < 490) random_sequence();
        idle_free = 1;
        repeat (20) random_sequence();
        idle_free = 0;
        drain();
    endtask

    task automatic test_backpressure();
        fork
            begin
                rx_hold = 1;
                repeat (40) @(posedge i_clk);
                rx_hold = 0;
            end
            repeat (12) random_sequence();
        join
        drain();
        repeat (10) random_sequence();
        drain();
    endtask

    initial begin
        errors = 0; beats_sent = 0; events_seen = 0; mice_seen = 0;
        rx_hold = 0; idle_free = 0;
        i_rst_n = 0; i_in_valid = 0; i_req_type = 0; i_data_byte = 0; i_out_stall = 0;
        clear_all();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        test_mouse_extremes();
        test_backpressure();
        test_random_stream();
        repeat (10) @(posedge i_clk);
        $display("sent %0d beats, %0d events, %0d mouse reports", beats_sent, events_seen,
                 mice_seen);
        $display("covered keys, controls, utf-8, csi, ss3, mouse, flush and stalls");
        if (errors == 0) $display("terminal_input_sequence_decoder_unit verification clean");
        else $display("terminal_input_sequence_decoder_unit verification failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("terminal_input_sequence_decoder_unit verification failed");
        $finish;
    end
endmodule
`default_nettype wire
